@@ sv/u2a_pkg.sv @@
// Shared types and constants for the UTF-8 to ASCII text filter.
// No dependencies; all design files but the checker import it.
`default_nettype none

package u2a_pkg;

  // byte classification constants
  localparam logic [7:0] B_SPACE      = 8'h20;
  localparam logic [7:0] B_TILDE      = 8'h7E;
  localparam logic [7:0] B_LEAD_MIN   = 8'hC0;
  localparam logic [7:0] B_MASK2      = 8'hE0;
  localparam logic [7:0] B_MASK3      = 8'hF0;
  localparam logic [7:0] B_MASK4      = 8'hF8;
  localparam logic [7:0] B_LEAD2      = 8'hC0;
  localparam logic [7:0] B_LEAD3      = 8'hE0;
  localparam logic [7:0] B_LEAD4      = 8'hF0;
  localparam logic [7:0] B_PUNCT_LEAD = 8'hE2;
  localparam logic [7:0] B_PUNCT_MID  = 8'h80;
  localparam logic [7:0] B_EN_DASH    = 8'h93;
  localparam logic [7:0] B_EM_DASH    = 8'h94;
  localparam logic [7:0] B_LSQUO      = 8'h98;
  localparam logic [7:0] B_RSQUO      = 8'h99;
  localparam logic [7:0] B_LDQUO      = 8'h9C;
  localparam logic [7:0] B_RDQUO      = 8'h9D;
  localparam logic [7:0] B_BULLET     = 8'hA2;
  localparam logic [7:0] B_ELLIPSIS   = 8'hA6;

  // emitted ASCII characters
  localparam logic [6:0] C_SPACE = 7'd32;
  localparam logic [6:0] C_DASH  = 7'd45;
  localparam logic [6:0] C_APOS  = 7'd39;
  localparam logic [6:0] C_QUOTE = 7'd34;
  localparam logic [6:0] C_STAR  = 7'd42;
  localparam logic [6:0] C_DOT   = 7'd46;
  localparam logic [6:0] C_NONE  = 7'd0;

  // one queue entry: everything one input byte causes
  typedef struct packed {
    logic       sp;        // a space goes out first
    logic       has_char;  // 0: bare end marker
    logic [6:0] ch;
    logic       dots;      // two more dots follow the char
    logic       last;      // end of text
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ sv/u2a_front.sv @@
// Front end: accepts input bytes, tracks UTF-8 sequence state and space collapse,
// and writes one bundle per productive byte into the queue. Uses u2a_pkg.
`default_nettype none

module u2a_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [7:0]          in_byte,
  input  wire                 in_eot,
  input  u2a_pkg::q_stat_t    q_stat,
  output logic                push,
  output u2a_pkg::bundle_t    push_data
);
  import u2a_pkg::*;

  logic [1:0] skip_left_r, skip_left_nxt;
  logic       punct_r, punct_nxt;
  logic       second_r, second_nxt;
  logic       pend_r, pend_nxt;
  logic       started_r, started_nxt;
  logic       fire;
  logic       emit;
  logic       dots;
  logic [6:0] ech;

  assign in_tready = !q_stat.full;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    skip_left_nxt = skip_left_r;
    punct_nxt     = punct_r;
    second_nxt    = second_r;
    pend_nxt      = pend_r;
    started_nxt   = started_r;
    emit          = 1'b0;
    dots          = 1'b0;
    ech           = C_NONE;

    if (skip_left_r != 2'd0) begin
      if (skip_left_r == 2'd2 && punct_r) begin
        second_nxt = (in_byte == B_PUNCT_MID);
      end else if (skip_left_r == 2'd1 && punct_r && second_r) begin
        case (in_byte)
          B_EN_DASH, B_EM_DASH: begin emit = 1'b1; ech = C_DASH;  end
          B_LSQUO,   B_RSQUO:   begin emit = 1'b1; ech = C_APOS;  end
          B_LDQUO,   B_RDQUO:   begin emit = 1'b1; ech = C_QUOTE; end
          B_BULLET:             begin emit = 1'b1; ech = C_STAR;  end
          B_ELLIPSIS:           begin emit = 1'b1; ech = C_DOT; dots = 1'b1; end
          default: ;
        endcase
      end
      skip_left_nxt = skip_left_r - 2'd1;
      if (skip_left_r == 2'd1) begin
        punct_nxt  = 1'b0;
        second_nxt = 1'b0;
      end
    end else if (in_byte >= B_SPACE && in_byte <= B_TILDE) begin
      if (in_byte == B_SPACE) begin
        if (started_r) pend_nxt = 1'b1;
      end else begin
        emit = 1'b1;
        ech  = in_byte[6:0];
      end
    end else if (in_byte >= B_LEAD_MIN) begin
      if ((in_byte & B_MASK2) == B_LEAD2) begin
        skip_left_nxt = 2'd1;
      end else if ((in_byte & B_MASK3) == B_LEAD3) begin
        skip_left_nxt = 2'd2;
        punct_nxt     = (in_byte == B_PUNCT_LEAD);
        second_nxt    = 1'b0;
      end else if ((in_byte & B_MASK4) == B_LEAD4) begin
        skip_left_nxt = 2'd3;
      end
    end

    // pending space clears and the text counts as started when a char goes out
    if (emit) begin
      pend_nxt    = 1'b0;
      started_nxt = 1'b1;
    end

    if (in_eot) begin
      skip_left_nxt = 2'd0;
      punct_nxt     = 1'b0;
      second_nxt    = 1'b0;
      pend_nxt      = 1'b0;
      started_nxt   = 1'b0;
    end
  end

  assign push               = fire && (emit || in_eot);
  assign push_data.sp       = emit && pend_r && started_r;
  assign push_data.has_char = emit;
  assign push_data.ch       = ech;
  assign push_data.dots     = dots;
  assign push_data.last     = in_eot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_left_r <= 2'd0;
      punct_r     <= 1'b0;
      second_r    <= 1'b0;
      pend_r      <= 1'b0;
      started_r   <= 1'b0;
    end else if (fire) begin
      skip_left_r <= skip_left_nxt;
      punct_r     <= punct_nxt;
      second_r    <= second_nxt;
      pend_r      <= pend_nxt;
      started_r   <= started_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/u2a_fifo.sv @@
// Short bundle queue between front and back ends.
// Uses u2a_pkg for the entry and status types.
`default_nettype none

module u2a_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  u2a_pkg::bundle_t    push_data,
  input  wire                 pop,
  output u2a_pkg::bundle_t    head,
  output u2a_pkg::q_stat_t    q_stat
);
  import u2a_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/u2a_back.sv @@
// Back end: expands the head bundle into single result transactions and
// holds them in the output register. Uses u2a_pkg.
`default_nettype none

module u2a_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  u2a_pkg::bundle_t    head,
  input  u2a_pkg::q_stat_t    q_stat,
  output logic                pop,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic                out_has,
  output logic [6:0]          out_char,
  output logic                out_last
);
  import u2a_pkg::*;

  logic [1:0] sub_r;
  logic [1:0] k;
  logic       load, fin;
  logic       valid_r;
  logic       has_r, last_r;
  logic [6:0] char_r;
  logic       item_has, item_last;
  logic [6:0] item_char;

  assign load = !q_stat.empty && (!valid_r || out_tready);

  // sub_r walks: optional space, the char, then two dots for an ellipsis
  always_comb begin
    k         = sub_r - {1'b0, head.sp};
    fin       = 1'b0;
    item_has  = head.has_char;
    item_char = head.ch;
    item_last = 1'b0;
    if (head.sp && sub_r == 2'd0) begin
      item_char = C_SPACE;
    end else begin
      if (k != 2'd0) item_char = C_DOT;
      fin       = head.dots ? (k == 2'd2) : 1'b1;
      item_last = head.last && fin;
    end
  end

  assign pop = load && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sub_r   <= fin ? 2'd0 : sub_r + 2'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      has_r  <= item_has;
      char_r <= item_char;
      last_r <= item_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_has    = has_r;
  assign out_char   = char_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

@@ sv/utf8_to_ascii_text_filter.sv @@
// UTF-8 to ASCII text filter, top level. Uses u2a_pkg, u2a_front, u2a_fifo, u2a_back.
// Data path: bundle queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; results leave one per
//   cycle while out_tready is high, through the output register and a QDEPTH-entry
//   bundle queue. A byte gives up to 4 results (space plus ellipsis).
// Reset: rst_n synchronous, active low; clears sequence state, queue and output valid.
`default_nettype none

module utf8_to_ascii_text_filter #(
  parameter int QDEPTH = 4   // bundle queue entries, 2 or more
) (
  input  wire        clk,
  input  wire        rst_n,
  // input channel
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] in_byte
  input  wire        in_tlast,   // end_of_text
  // result channel
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero fill
  output logic       out_tuser,  // has_char
  output logic       out_tlast   // last
);
  import u2a_pkg::*;

  bundle_t    push_data, head;
  q_stat_t    q_stat;
  logic       push, pop;
  logic [6:0] out_char;

  // front: classify bytes, one bundle per byte that produces anything
  u2a_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_eot    (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // queue absorbs multi-result bundles so the front keeps taking bytes
  u2a_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: one result transaction per cycle from the head bundle unless stalled
  u2a_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_has    (out_tuser),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

@@ sv/u2a_checker.sv @@
// Port-level checks for the text filter, bound to the top level.
// Depends on utf8_to_ascii_text_filter only through its ports.
`default_nettype none

module u2a_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire       out_tuser,
  input wire       out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a bare end marker only closes a text
  a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("bare marker without last");

  // characters are printable ASCII
  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata >= 8'd32 && out_tdata <= 8'd126)
    else $error("non-printable character out");

  // trailing spaces are trimmed
  a_no_trail_sp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata == 8'd32 |-> !out_tlast)
    else $error("space closes a text");

endmodule

bind utf8_to_ascii_text_filter u2a_checker u_u2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
